>>> rtl/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared types and constants for the modular exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

  // Default operand width in bits.
  localparam int unsigned WIDTH_DEFAULT = 16;

  // Operation run by the shared modular multiply unit.
  typedef enum logic [1:0] {
    OP_RED = 2'd0,  // reduce the base modulo the modulus
    OP_ACC = 2'd1,  // result times square
    OP_SQ  = 2'd2   // square times square
  } op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture a new transfer and initialize
    logic start_op;  // clear the multiply unit and pick its multiplier
    logic step;      // advance the multiply unit by one multiplier bit
    op_e  op;        // operation that is running
    logic out_load;  // capture the final residue
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;       // current step handles the final multiplier bit
    logic exp_lsb;    // exponent bit under consideration
    logic exp_zero;   // no set exponent bits remain
    logic mod_small;  // modulus is zero or one
  } sts_t;

endpackage

>>> rtl/mexp_dp.sv
// ----------------------------------------------------------------------------
// mexp_dp
// Datapath: operand registers and a bit-serial modular multiply unit that
// also performs the initial reduction of the base.
// ----------------------------------------------------------------------------
module mexp_dp #(
  parameter int unsigned WIDTH = mexp_pkg::WIDTH_DEFAULT
) (
  input  logic                clk_i,
  input  mexp_pkg::cmd_t      cmd_i,
  output mexp_pkg::sts_t      sts_o,
  input  logic [WIDTH-1:0]    base_i,
  input  logic [WIDTH-1:0]    exp_i,
  input  logic [WIDTH-1:0]    mod_i,
  output logic [WIDTH-1:0]    residue_o
);

  localparam int unsigned CntW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  logic [WIDTH-1:0] exp_q;
  logic [WIDTH-1:0] mod_q;
  logic [WIDTH-1:0] acc_q;
  logic [WIDTH-1:0] sq_q;
  logic [WIDTH-1:0] macc_q;
  logic [WIDTH-1:0] macc_d;
  logic [WIDTH-1:0] mb_q;
  logic [WIDTH-1:0] res_q;
  logic [CntW-1:0]  cnt_q;

  logic [WIDTH-1:0] addend;
  logic [WIDTH+1:0] sum;
  logic [WIDTH+1:0] mod1;
  logic [WIDTH+1:0] mod2;
  logic             last;

  assign last = (cnt_q == CntW'(WIDTH - 1));

  // One multiplier bit per cycle: double the partial result and add the
  // selected operand. The sum stays below three times the modulus, so
  // subtracting zero, one or two moduli brings it back into range.
  always_comb begin
    addend = '0;
    if (cmd_i.op == mexp_pkg::OP_RED) begin
      addend[0] = mb_q[WIDTH-1];
    end else if (mb_q[WIDTH-1]) begin
      addend = sq_q;
    end
    sum  = {1'b0, macc_q, 1'b0} + {2'b00, addend};
    mod1 = {2'b00, mod_q};
    mod2 = {1'b0, mod_q, 1'b0};
    if (sum >= mod2) begin
      macc_d = WIDTH'(sum - mod2);
    end else if (sum >= mod1) begin
      macc_d = WIDTH'(sum - mod1);
    end else begin
      macc_d = sum[WIDTH-1:0];
    end
  end

  // Operand, multiply unit and write-back registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      exp_q  <= exp_i;
      mod_q  <= mod_i;
      acc_q  <= WIDTH'(1);
      mb_q   <= base_i;
      macc_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (cmd_i.start_op) begin
        macc_q <= '0;
        cnt_q  <= '0;
        // A start that comes with the last step of a multiply by the square
        // sets up the squaring, which takes the square as its multiplier.
        mb_q   <= (cmd_i.op == mexp_pkg::OP_ACC && !cmd_i.step) ? acc_q : sq_q;
      end else if (cmd_i.step) begin
        macc_q <= macc_d;
        mb_q   <= {mb_q[WIDTH-2:0], 1'b0};
        cnt_q  <= cnt_q + CntW'(1);
      end
      // The finished product goes back to its destination register.
      if (cmd_i.step && last) begin
        case (cmd_i.op)
          mexp_pkg::OP_RED: sq_q <= macc_d;
          mexp_pkg::OP_ACC: acc_q <= macc_d;
          mexp_pkg::OP_SQ: begin
            sq_q  <= macc_d;
            exp_q <= {1'b0, exp_q[WIDTH-1:1]};
          end
          default: ;
        endcase
      end
    end
    if (cmd_i.out_load) begin
      res_q <= sts_o.mod_small ? '0 : acc_q;
    end
  end

  assign sts_o.last      = last;
  assign sts_o.exp_lsb   = exp_q[0];
  assign sts_o.exp_zero  = (exp_q == '0);
  assign sts_o.mod_small = (mod_q[WIDTH-1:1] == '0);
  assign residue_o       = res_q;

endmodule

>>> rtl/mexp_ctrl.sv
// ----------------------------------------------------------------------------
// mexp_ctrl
// Controller: sequences the base reduction and the square-and-multiply
// passes, and owns the input handshake and the output valid flag.
// ----------------------------------------------------------------------------
module mexp_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output mexp_pkg::cmd_t cmd_o,
  input  mexp_pkg::sts_t sts_i
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RED  = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_MULA = 3'd3;
  localparam logic [2:0] S_MULS = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state_q;
  logic [2:0] state_d;
  logic       out_valid_q;
  logic       out_valid_d;
  logic       in_xfer;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;

  // Next-state and command logic.
  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    cmd_o.op        = mexp_pkg::OP_RED;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          cmd_o.load = 1'b1;
          state_d    = S_RED;
        end
      end
      S_RED: begin
        if (sts_i.mod_small) begin
          state_d = S_FIN;
        end else begin
          cmd_o.step = 1'b1;
          if (sts_i.last) begin
            state_d = S_CHK;
          end
        end
      end
      S_CHK: begin
        cmd_o.start_op = !sts_i.exp_zero;
        if (sts_i.exp_zero) begin
          state_d = S_FIN;
        end else if (sts_i.exp_lsb) begin
          cmd_o.op = mexp_pkg::OP_ACC;
          state_d  = S_MULA;
        end else begin
          cmd_o.op = mexp_pkg::OP_SQ;
          state_d  = S_MULS;
        end
      end
      S_MULA: begin
        cmd_o.op   = mexp_pkg::OP_ACC;
        cmd_o.step = 1'b1;
        if (sts_i.last) begin
          // The squaring pass reads the square, which this pass leaves alone.
          cmd_o.start_op = 1'b1;
          state_d        = S_MULS;
        end
      end
      S_MULS: begin
        cmd_o.op   = mexp_pkg::OP_SQ;
        cmd_o.step = 1'b1;
        if (sts_i.last) begin
          state_d = S_CHK;
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output valid flag: set when a residue is captured, cleared on transfer.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // A waiting residue is never overwritten before its transfer.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("residue overwritten before transfer");

  // An accepted input always starts with the base reduction.
  a_start_red: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == S_RED))
    else $error("accepted input did not start reduction");

  // A finished multiply by the square is always followed by a squaring.
  a_mula_to_muls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MULA && sts_i.last) |=> (state_q == S_MULS))
    else $error("multiply pass not followed by squaring");

  // The multiply unit only advances while a pass is running.
  a_step_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step |-> (state_q == S_RED || state_q == S_MULA || state_q == S_MULS))
    else $error("multiply unit stepped outside a pass");

endmodule

>>> rtl/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// modular_exponentiation
// Computes base to the power exponent modulo modulus by right-to-left
// square-and-multiply with a shared bit-serial modular multiplier.
// ----------------------------------------------------------------------------
// One transfer in gives one residue out. A bit-serial modular multiplier
// handles one multiplier bit per cycle, so every reduction or product runs
// bit by bit through that one shared unit. An item is accepted, the base is
// reduced, then each exponent bit up to the highest set one gets a check, a
// multiply by the square when the bit is set and a squaring; a final check
// and the capture of the result close the item. A modulus of zero or one
// returns 0 without any multiply passes. Another item is accepted once the
// result sits in the output register.
module modular_exponentiation #(
  parameter int unsigned WIDTH = mexp_pkg::WIDTH_DEFAULT
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // base_value, exponent_value, modulus_value from the lowest bit up
  input  logic [((3*WIDTH+7)/8)*8-1:0]          s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // residue
  output logic [((WIDTH+7)/8)*8-1:0]            m_axis_tdata
);

  mexp_pkg::cmd_t   cmd;
  mexp_pkg::sts_t   sts;
  logic [WIDTH-1:0] residue;

  mexp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  mexp_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk_i     (clk_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .base_i    (s_axis_tdata[WIDTH-1:0]),
    .exp_i     (s_axis_tdata[2*WIDTH-1:WIDTH]),
    .mod_i     (s_axis_tdata[3*WIDTH-1:2*WIDTH]),
    .residue_o (residue)
  );

  // Zero-fill the result up to whole bytes.
  always_comb begin
    m_axis_tdata              = '0;
    m_axis_tdata[WIDTH-1:0]   = residue;
  end

endmodule

>>> bench/tb_modular_exponentiation.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_modular_exponentiation
// Self-checking bench for the modular exponentiation block.
// ----------------------------------------------------------------------------
// Operand triples are queued by the stimulus process and offered on the input
// stream by a driver. A monitor predicts the residue of every accepted
// transfer with plain integer arithmetic and checks each output transfer
// against the oldest prediction. The input and output sides idle at random in
// three phases, the output side holds off for a long stretch once, and the
// input side pauses until all residues are back between phases.
// ----------------------------------------------------------------------------
module tb_modular_exponentiation;

  localparam int unsigned WIDTH       = mexp_pkg::WIDTH_DEFAULT;
  localparam int unsigned IN_BITS     = ((3 * WIDTH + 7) / 8) * 8;
  localparam int unsigned OUT_BITS    = ((WIDTH + 7) / 8) * 8;
  localparam int unsigned ITEM_CYCLES = 2 * WIDTH * WIDTH + 2 * WIDTH + 3;
  localparam int unsigned HOLD_CYCLES = 3000;
  localparam int unsigned PHASE_ITEMS = 280;
  localparam int unsigned MAX_CYCLES  = 2_500_000;

  // Operands as they sit on the input bus, base in the lowest bits.
  typedef struct packed {
    logic [WIDTH-1:0] modulus;
    logic [WIDTH-1:0] exponent;
    logic [WIDTH-1:0] base;
  } operands_t;

  typedef struct {
    operands_t        operands;
    logic [WIDTH-1:0] residue;
  } power_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [IN_BITS-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OUT_BITS-1:0] m_axis_tdata;

  operands_t   operand_queue[$];
  power_t      residue_queue[$];
  int unsigned tx_idle_pct    = 0;
  int unsigned rx_idle_pct    = 0;
  int unsigned rx_hold_left   = 0;
  int unsigned cycle_count    = 0;
  int unsigned accepted_count = 0;
  int unsigned mismatch_count = 0;
  bit          in_accepted    = 1'b0;

  modular_exponentiation #(
    .WIDTH(WIDTH)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Free-running clock.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Right-to-left square-and-multiply with every product reduced on the spot.
  function automatic logic [WIDTH-1:0] expected_power(operands_t op);
    logic [2*WIDTH-1:0] product;
    logic [WIDTH-1:0]   result;
    logic [WIDTH-1:0]   square;
    if (op.modulus < 2) begin
      return '0;
    end
    result = WIDTH'(1);
    square = op.base % op.modulus;
    for (int unsigned i = 0; i < WIDTH; i++) begin
      if (op.exponent[i]) begin
        product = (2*WIDTH)'(result) * (2*WIDTH)'(square);
        result  = WIDTH'(product % op.modulus);
      end
      product = (2*WIDTH)'(square) * (2*WIDTH)'(square);
      square  = WIDTH'(product % op.modulus);
    end
    return result;
  endfunction

  // Mostly full-range operands, with a share of the corner regions mixed in.
  function automatic operands_t random_operands();
    operands_t op;
    op.base     = WIDTH'($urandom());
    op.exponent = WIDTH'($urandom());
    op.modulus  = WIDTH'($urandom());
    case ($urandom_range(11))
      0: op.modulus = WIDTH'($urandom_range(1));
      1: op.modulus = WIDTH'($urandom_range(15, 2));
      2: op.exponent = '0;
      3: op.base = '0;
      4: op.exponent = WIDTH'($urandom_range(7));
      5: begin
        op.modulus = WIDTH'($urandom_range(255, 2));
        op.base    = op.modulus * WIDTH'($urandom_range(200));
      end
      6: op.base = WIDTH'($urandom_range(2));
      default: ;
    endcase
    return op;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // Appends one operand triple to the pending input items.
  task automatic enqueue_operands(operands_t op);
    operand_queue = {operand_queue, op};
  endtask

  // Input driver: a valid item stays on the bus until its transfer.
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_accepted)) begin
      if (operand_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= operand_queue.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Output side: random back-pressure plus one long hold-off.
  always @(negedge clk_i) begin
    if (rx_hold_left != 0) begin
      rx_hold_left  = rx_hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Monitor: predict on each input transfer, check on each output transfer.
  always @(posedge clk_i) begin
    power_t    want;
    operands_t op;
    in_accepted = s_axis_tvalid && s_axis_tready;
    if (in_accepted) begin
      op            = s_axis_tdata[3*WIDTH-1:0];
      want.operands = op;
      want.residue  = expected_power(op);
      residue_queue = {residue_queue, want};
      accepted_count++;
    end
    if (m_axis_tvalid && m_axis_tready) begin
      if (residue_queue.size() == 0) begin
        report_mismatch($sformatf("unexpected residue %0d", m_axis_tdata[WIDTH-1:0]));
      end else begin
        want = residue_queue.pop_front();
        if (m_axis_tdata[WIDTH-1:0] !== want.residue) begin
          report_mismatch($sformatf("%0d^%0d mod %0d: residue %0d, expected %0d",
                                    want.operands.base, want.operands.exponent,
                                    want.operands.modulus, m_axis_tdata[WIDTH-1:0],
                                    want.residue));
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= MAX_CYCLES) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic push_operands(int unsigned base, int unsigned exponent,
                               int unsigned modulus);
    operands_t op;
    op.base     = WIDTH'(base);
    op.exponent = WIDTH'(exponent);
    op.modulus  = WIDTH'(modulus);
    enqueue_operands(op);
  endtask

  // The sender pauses here until every outstanding residue has come back.
  task automatic wait_for_drain();
    while (operand_queue.size() != 0 || s_axis_tvalid || residue_queue.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Stimulus sequencing.
  initial begin
    int unsigned start_count;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed corners, sender idling lightly and receiver heavily.
    tx_idle_pct = 14;
    rx_idle_pct = 48;
    push_operands(5, 3, 0);              // modulus zero
    push_operands(65535, 65535, 1);      // modulus one
    push_operands(0, 0, 0);
    push_operands(7, 0, 2);              // exponent zero, smallest modulus
    push_operands(65535, 0, 65535);      // exponent zero, largest modulus
    push_operands(0, 1, 13);             // zero base
    push_operands(0, 65535, 65535);
    push_operands(65535, 5, 7);          // base above modulus
    push_operands(13, 9, 13);            // base equal to modulus
    push_operands(65535, 65535, 65535);
    push_operands(65534, 65535, 65535);
    push_operands(2, 65520, 65521);      // prime modulus, Fermat's little theorem
    push_operands(3, 32768, 65521);      // single top exponent bit
    push_operands(12345, 1, 65534);      // exponent one
    push_operands(1, 65535, 40000);      // unit base
    push_operands(65535, 65535, 2);
    push_operands(43690, 21845, 52429);  // alternating bit patterns
    push_operands(21845, 43690, 32768);
    wait_for_drain();

    // Random, first idling mix.
    repeat (PHASE_ITEMS) enqueue_operands(random_operands());
    wait_for_drain();

    // Random, idling mix swapped.
    tx_idle_pct = 48;
    rx_idle_pct = 14;
    repeat (PHASE_ITEMS) enqueue_operands(random_operands());
    wait_for_drain();

    // Random, no idling; a long receiver hold-off fills the block up.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (PHASE_ITEMS) enqueue_operands(random_operands());
    start_count = accepted_count;
    while (accepted_count < start_count + 20) @(posedge clk_i);
    rx_hold_left = HOLD_CYCLES;
    wait_for_drain();

    // Let any stray output show up before the verdict.
    repeat (ITEM_CYCLES + 50) @(posedge clk_i);
    if (mismatch_count == 0 && residue_queue.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
